// ===== rtl/core/lrul_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrul_pkg
// shared widths and request codes for the indexed lru list manager
// ----------------------------------------------------------------------------
package lrul_pkg;

  localparam int IDX_W = 10;
  localparam int OP_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_HEAD  = 3'd0,
    OP_ADD_TAIL  = 3'd1,
    OP_MOVE_HEAD = 3'd2,
    OP_MOVE_TAIL = 3'd3,
    OP_REMOVE    = 3'd4,
    OP_QUERY     = 3'd5
  } op_t;

endpackage

// ===== rtl/core/lrul_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrul channel interfaces
// request, response and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface lrul_req_if;
  import lrul_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, output opcode, output entry_index, input ready);
  modport sink   (input valid, input opcode, input entry_index, output ready);
endinterface

interface lrul_rsp_if;
  import lrul_pkg::*;
  logic             valid;
  logic             ready;
  logic             applied;
  logic             was_linked;
  logic             list_empty;
  logic [IDX_W-1:0] head_entry;
  logic [IDX_W-1:0] tail_entry;

  modport source (output valid, output applied, output was_linked, output list_empty,
                  output head_entry, output tail_entry, input ready);
  modport sink   (input valid, input applied, input was_linked, input list_empty,
                  input head_entry, input tail_entry, output ready);
endinterface

interface lrul_cfg_if;
  logic valid;
  logic ready;
  logic lru_enable;

  modport source (output valid, output lru_enable, input ready);
  modport sink   (input valid, input lru_enable, output ready);
endinterface

// ===== rtl/core/indexed_lru_list_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_lru_list_manager
// lru recency order kept as an index-linked circular doubly linked list
// ----------------------------------------------------------------------------
// The recency order lives in two link memories (prev and next, one entry per
// pool entry); the sentinel entry's own links are held in head/tail registers
// and are the list ends reported with every result. Each request transaction
// first reads the named entry's two links, then drives the single write port
// of each link memory in S_EVAL, S_WR1 and S_WR2 (a move rewrites up
// to three links in each memory, e.g. neighbor, new neighbor and the entry
// itself). A request is accepted only in idle, one at a time; the response
// sits in an output register, so the next request may be taken while it
// waits, and a request whose response cannot be loaded stalls until the
// output register frees up. After reset a clearing pass points every
// entry at itself; no request is accepted during it, configuration
// writes are taken at all times. lru_enable should only be written while
// no request is in flight.
// ----------------------------------------------------------------------------
module indexed_lru_list_manager #(
  parameter int POOL_ENTRIES   = 1024,
  parameter int SENTINEL_INDEX = 0
) (
  input logic         clk,
  input logic         rst,
  lrul_req_if.sink    req,
  lrul_rsp_if.source  rsp,
  lrul_cfg_if.sink    cfg
);
  import lrul_pkg::*;

  localparam int LW = $clog2(POOL_ENTRIES);
  localparam logic [LW-1:0] SENT     = LW'(SENTINEL_INDEX);
  localparam logic [LW-1:0] LAST_IDX = LW'(POOL_ENTRIES - 1);

  // one write to one link memory
  typedef struct packed {
    logic          we;
    logic [LW-1:0] addr;
    logic [LW-1:0] data;
  } wr_t;

  // one write step: a write to each memory in the same cycle
  typedef struct packed {
    wr_t p;
    wr_t n;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_WR1,
    S_WR2,
    S_HOLD
  } state_t;

  state_t state;

  // link memories
  logic [LW-1:0] prev_mem [POOL_ENTRIES];
  logic [LW-1:0] next_mem [POOL_ENTRIES];
  logic [LW-1:0] rd_prev;
  logic [LW-1:0] rd_next;

  // sentinel links: head is the root's next, tail the root's prev
  logic [LW-1:0] head, head_next;
  logic [LW-1:0] tail, tail_next;

  logic          lru_enable;
  logic [LW-1:0] clr_idx;
  logic [OP_W-1:0] op;
  logic [LW-1:0] ent;
  logic          ent_ok;
  logic          applied, applied_next;
  logic          was_linked;
  slot_t         slot0, slot1, slot2;
  slot_t         slot1_q, slot2_q;
  wr_t           pw, nw;
  logic          rd_en;
  logic          out_free;
  logic          rsp_load;
  logic          ok_idx;

  function automatic wr_t mk_wr(input logic we, input logic [LW-1:0] a,
                                input logic [LW-1:0] d);
    wr_t w;
    w.we   = we;
    w.addr = a;
    w.data = d;
    return w;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rd_en     = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  // response register takes the finished request this cycle
  assign rsp_load  = ((state == S_WR2) || (state == S_HOLD)) && out_free;

  // index is in the pool and not the root
  assign ok_idx = (32'(req.entry_index) < 32'(POOL_ENTRIES)) &&
                  (req.entry_index != IDX_W'(SENTINEL_INDEX));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      lru_enable <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      lru_enable <= cfg.lru_enable;
    end
  end

  // guard check and write plan, from the links read for the entry
  always_comb begin
    logic unl, lnk, distinct;
    logic [LW-1:0] p, n;
    p            = rd_prev;
    n            = rd_next;
    unl          = (n == ent) && (p == ent);
    lnk          = (n != ent) && (p != ent);
    distinct     = (n != p);
    slot0        = '0;
    slot1        = '0;
    slot2        = '0;
    applied_next = 1'b0;
    head_next    = head;
    tail_next    = tail;
    if (state == S_EVAL) begin
      unique case (op)
        OP_ADD_HEAD: begin
          if (ent_ok && unl) begin
            applied_next = 1'b1;
            slot0.p = mk_wr(1'b1, head, ent);
            slot1.p = mk_wr(1'b1, ent, SENT);
            slot0.n = mk_wr(1'b1, ent, head);
            head_next = ent;
            if (head == SENT) begin
              tail_next = ent;
            end
          end
        end
        OP_ADD_TAIL: begin
          if (lru_enable && ent_ok && unl) begin
            applied_next = 1'b1;
            slot0.p = mk_wr(1'b1, ent, tail);
            slot0.n = mk_wr(1'b1, ent, SENT);
            slot1.n = mk_wr(1'b1, tail, ent);
            tail_next = ent;
            if (tail == SENT) begin
              head_next = ent;
            end
          end
        end
        OP_MOVE_HEAD: begin
          if (lru_enable && ent_ok && lnk && (p != SENT) && distinct) begin
            // unlink, then insert after the root; the self-links are overwritten
            applied_next = 1'b1;
            slot0.p = mk_wr(1'b1, n, p);
            slot1.p = mk_wr(1'b1, head, ent);
            slot2.p = mk_wr(1'b1, ent, SENT);
            slot0.n = mk_wr(1'b1, p, n);
            slot1.n = mk_wr(1'b1, ent, head);
            head_next = ent;
            if (n == SENT) begin
              tail_next = p;
            end
          end
        end
        OP_MOVE_TAIL: begin
          if (lru_enable && ent_ok && lnk && (n != SENT) && distinct) begin
            applied_next = 1'b1;
            slot0.p = mk_wr(1'b1, n, p);
            slot1.p = mk_wr(1'b1, ent, tail);
            slot0.n = mk_wr(1'b1, p, n);
            slot1.n = mk_wr(1'b1, ent, SENT);
            slot2.n = mk_wr(1'b1, tail, ent);
            tail_next = ent;
            if (p == SENT) begin
              head_next = n;
            end
          end
        end
        OP_REMOVE: begin
          if (ent_ok && lnk) begin
            applied_next = 1'b1;
            slot0.p = mk_wr(1'b1, n, p);
            slot1.p = mk_wr(1'b1, ent, ent);
            slot0.n = mk_wr(1'b1, p, n);
            slot1.n = mk_wr(1'b1, ent, ent);
            if (n == SENT) begin
              tail_next = p;
            end
            if (p == SENT) begin
              head_next = n;
            end
          end
        end
        default: begin
          // query and unused codes change nothing
        end
      endcase
    end
  end

  // write port selection: clearing pass, then the three planned steps
  always_comb begin
    pw = '0;
    nw = '0;
    unique case (state)
      S_CLEAR: begin
        pw = mk_wr(1'b1, clr_idx, clr_idx);
        nw = mk_wr(1'b1, clr_idx, clr_idx);
      end
      S_EVAL: begin
        pw = slot0.p;
        nw = slot0.n;
      end
      S_WR1: begin
        pw = slot1_q.p;
        nw = slot1_q.n;
      end
      S_WR2: begin
        pw = slot2_q.p;
        nw = slot2_q.n;
      end
      default: begin
      end
    endcase
  end

  // link memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (pw.we) begin
      prev_mem[pw.addr] <= pw.data;
    end
    if (nw.we) begin
      next_mem[nw.addr] <= nw.data;
    end
    if (rd_en) begin
      rd_prev <= prev_mem[LW'(req.entry_index)];
      rd_next <= next_mem[LW'(req.entry_index)];
    end
  end

  // sequencer, list ends and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      head      <= SENT;
      tail      <= SENT;
      rsp.valid <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (rd_en) begin
            op     <= req.opcode;
            ent    <= LW'(req.entry_index);
            ent_ok <= ok_idx;
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          applied    <= applied_next;
          was_linked <= ent_ok && (rd_next != ent);
          slot1_q    <= slot1;
          slot2_q    <= slot2;
          state      <= S_WR1;
        end
        S_WR1: begin
          state <= S_WR2;
        end
        S_WR2, S_HOLD: begin
          // head/tail are final since the evaluate cycle
          if (rsp_load) begin
            rsp.valid      <= 1'b1;
            rsp.applied    <= applied;
            rsp.was_linked <= was_linked;
            rsp.list_empty <= (head == SENT);
            rsp.head_entry <= IDX_W'(head);
            rsp.tail_entry <= IDX_W'(tail);
            state          <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the root's two links are either both itself or both real entries
  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    (head == SENT) == (tail == SENT))
    else $error("list ends disagree on emptiness");

  // every accepted request is followed by a pending response
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> ##4 rsp.valid)
    else $error("response missing after request");

  // an empty list reports the root at both ends
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.list_empty) |->
      (rsp.head_entry == IDX_W'(SENTINEL_INDEX)) &&
      (rsp.tail_entry == IDX_W'(SENTINEL_INDEX)))
    else $error("empty list with non-root ends");
`endif

endmodule

// ===== sim/lrul_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrul_list_checker
// watches the request, response and configuration channels of the lru list
// manager, keeps its own copy of the link memories and checks every response
// ----------------------------------------------------------------------------
module lrul_list_checker #(
  parameter int POOL_ENTRIES   = 1024,
  parameter int SENTINEL_INDEX = 0
) (
  input  logic clk,
  input  logic rst,
  lrul_req_if  req,
  lrul_rsp_if  rsp,
  lrul_cfg_if  cfg,
  output int   failures,
  output int   outstanding
);
  import lrul_pkg::*;

  localparam int                REPORT_LIMIT = 10;
  localparam logic [IDX_W-1:0] ROOT         = IDX_W'(SENTINEL_INDEX);

  typedef struct packed {
    logic             applied;
    logic             was_linked;
    logic             list_empty;
    logic [IDX_W-1:0] head_entry;
    logic [IDX_W-1:0] tail_entry;
  } list_status_t;

  logic [IDX_W-1:0] prev_of [POOL_ENTRIES];
  logic [IDX_W-1:0] next_of [POOL_ENTRIES];
  logic             lru_on;
  list_status_t     status_q[$];

  // place entry e between p and n
  function automatic void splice_in(input logic [IDX_W-1:0] e, p, n);
    prev_of[n] = e;
    next_of[e] = n;
    prev_of[e] = p;
    next_of[p] = e;
  endfunction

  // take entry e out and let it point to itself
  function automatic void splice_out(input logic [IDX_W-1:0] e);
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] n;
    p = prev_of[e];
    n = next_of[e];
    prev_of[n] = p;
    next_of[p] = n;
    prev_of[e] = e;
    next_of[e] = e;
  endfunction

  function automatic list_status_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [IDX_W-1:0] e);
    list_status_t     st;
    logic             legal;
    logic             unlinked;
    logic             linked;
    logic             split;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] n;
    st       = '0;
    unlinked = 1'b0;
    linked   = 1'b0;
    split    = 1'b0;
    p        = '0;
    n        = '0;
    legal    = (int'(e) < POOL_ENTRIES) && (e != ROOT);
    if (legal) begin
      p             = prev_of[e];
      n             = next_of[e];
      st.was_linked = (n != e);
      unlinked      = (n == e) && (p == e);
      linked        = (n != e) && (p != e);
      split         = (n != p);
    end
    case (op)
      OP_ADD_HEAD: begin
        if (legal && unlinked) begin
          splice_in(e, ROOT, next_of[ROOT]);
          st.applied = 1'b1;
        end
      end
      OP_ADD_TAIL: begin
        if (lru_on && legal && unlinked) begin
          splice_in(e, prev_of[ROOT], ROOT);
          st.applied = 1'b1;
        end
      end
      OP_MOVE_HEAD: begin
        if (lru_on && legal && linked && p != ROOT && split) begin
          splice_out(e);
          splice_in(e, ROOT, next_of[ROOT]);
          st.applied = 1'b1;
        end
      end
      OP_MOVE_TAIL: begin
        if (lru_on && legal && linked && n != ROOT && split) begin
          splice_out(e);
          splice_in(e, prev_of[ROOT], ROOT);
          st.applied = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (legal && linked) begin
          splice_out(e);
          st.applied = 1'b1;
        end
      end
      default: ;
    endcase
    st.list_empty = (next_of[ROOT] == ROOT);
    st.head_entry = next_of[ROOT];
    st.tail_entry = prev_of[ROOT];
    return st;
  endfunction

  always @(posedge clk) begin : monitor
    list_status_t want;
    list_status_t got;
    if (rst) begin
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        prev_of[i] = IDX_W'(i);
        next_of[i] = IDX_W'(i);
      end
      lru_on = 1'b1;
      status_q.delete();
      failures = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        lru_on = cfg.lru_enable;
      end
      if (req.valid && req.ready) begin
        status_q.push_back(apply_request(req.opcode, req.entry_index));
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.applied, rsp.was_linked, rsp.list_empty, rsp.head_entry,
                rsp.tail_entry};
        if (status_q.size() == 0) begin
          if (failures < REPORT_LIMIT) begin
            $display("%0t: response with nothing pending: applied=%0d head=%0d tail=%0d",
                     $realtime, got.applied, got.head_entry, got.tail_entry);
          end
          failures++;
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            if (failures < REPORT_LIMIT) begin
              $display("%0t: mismatch expected applied=%0d linked=%0d empty=%0d head=%0d tail=%0d",
                       $realtime, want.applied, want.was_linked, want.list_empty,
                       want.head_entry, want.tail_entry);
              $display("%0t:          actual   applied=%0d linked=%0d empty=%0d head=%0d tail=%0d",
                       $realtime, got.applied, got.was_linked, got.list_empty,
                       got.head_entry, got.tail_entry);
            end
            failures++;
          end
        end
      end
    end
    outstanding = status_q.size();
  end

endmodule

// ===== sim/indexed_lru_list_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_lru_list_manager_tb
// drives request transactions and lru_enable writes into the list manager,
// with directed corner cases first and then random phases of varying
// backpressure; a side checker predicts and compares every response
// ----------------------------------------------------------------------------
module indexed_lru_list_manager_tb;
  import lrul_pkg::*;

  localparam int POOL_ENTRIES    = 1024;
  localparam int SENTINEL_INDEX  = 0;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 160;

  // opcodes outside the enum, the block must treat them as no-ops
  localparam logic [OP_W-1:0]  OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0]  OP_SPARE_7 = 3'd7;
  localparam logic [IDX_W-1:0] ROOT_ENTRY = IDX_W'(SENTINEL_INDEX);
  localparam logic [IDX_W-1:0] TOP_ENTRY  = '1;

  // lru_enable per random phase, bit n for phase n
  localparam logic [NUM_PHASES-1:0] PHASE_LRU_ON = 6'b101101;

  logic clk;
  logic rst;
  int   cycle_count;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  int   failures;
  int   outstanding;

  lrul_req_if req_ch ();
  lrul_rsp_if rsp_ch ();
  lrul_cfg_if cfg_ch ();

  indexed_lru_list_manager #(
    .POOL_ENTRIES   (POOL_ENTRIES),
    .SENTINEL_INDEX (SENTINEL_INDEX)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  lrul_list_checker #(
    .POOL_ENTRIES   (POOL_ENTRIES),
    .SENTINEL_INDEX (SENTINEL_INDEX)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs; the slowest legal run is far below this
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // response backpressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // one request transaction; starts and returns at a falling edge and leaves
  // valid high so that back-to-back items need no idle gap
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.entry_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid, wait until every response is back, then let the block finish
  // its link writes before anything touches the register
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // single transaction on the configuration channel
  task automatic write_lru_enable(input logic on);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.lru_enable <= on;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    int               pick;

    // every input known from time zero
    rst                = 1'b1;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    req_ch.valid       = 1'b0;
    req_ch.opcode      = OP_QUERY;
    req_ch.entry_index = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.lru_enable  = 1'b0;
    rsp_ch.ready       = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // the register is taken even during the clearing pass; requests wait for it
    write_lru_enable(1'b1);

    // ---- directed part, lru mode on ----
    send_request(OP_QUERY,     ROOT_ENTRY);   // empty list reports sentinel ends
    send_request(OP_ADD_HEAD,  10'd5);        // first entry
    send_request(OP_MOVE_HEAD, 10'd5);        // sole entry: prev equals next, fails
    send_request(OP_MOVE_TAIL, 10'd5);        // same on the tail side
    send_request(OP_ADD_TAIL,  TOP_ENTRY);    // highest index at the tail
    send_request(OP_ADD_HEAD,  10'd1);        // list now 1, 5, top
    send_request(OP_ADD_HEAD,  10'd5);        // add of a linked entry fails
    send_request(OP_MOVE_HEAD, 10'd1);        // head to head fails
    send_request(OP_MOVE_TAIL, TOP_ENTRY);    // tail to tail fails
    send_request(OP_MOVE_HEAD, TOP_ENTRY);    // tail jumps to head
    send_request(OP_MOVE_TAIL, 10'd1);        // middle entry goes to tail
    send_request(OP_MOVE_HEAD, 10'd5);        // middle entry goes to head
    // sentinel named by head add, tail add, tail move and remove, never applies
    send_request(OP_ADD_HEAD,  ROOT_ENTRY);
    send_request(OP_ADD_TAIL,  ROOT_ENTRY);
    send_request(OP_MOVE_TAIL, ROOT_ENTRY);
    send_request(OP_REMOVE,    ROOT_ENTRY);
    // spare opcodes change nothing
    send_request(OP_SPARE_6,   10'd5);
    send_request(OP_SPARE_7,   TOP_ENTRY);
    send_request(OP_REMOVE,    TOP_ENTRY);
    send_request(OP_REMOVE,    TOP_ENTRY);    // already unlinked, fails

    // ---- directed part, lru mode off: tail add and moves are blocked ----
    settle();
    write_lru_enable(1'b0);
    send_request(OP_ADD_TAIL,  10'd2);
    send_request(OP_MOVE_HEAD, 10'd1);
    send_request(OP_MOVE_TAIL, 10'd5);
    send_request(OP_ADD_HEAD,  10'h2aa);      // alternating index bits
    send_request(OP_REMOVE,    10'd5);

    // ---- random phases ----
    // the working set is mostly a handful of low entries so moves and removes
    // hit linked entries often; the rest spans the whole index range
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      write_lru_enable(PHASE_LRU_ON[phase]);
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 71;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 71;
        end
        default: begin
          sender_idle_pct    = 7;
          receiver_stall_pct = 7;
        end
      endcase
      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
          op = OP_W'($urandom_range(OP_ADD_HEAD, OP_REMOVE));
        end else begin
          op = OP_W'($urandom_range(OP_QUERY, OP_SPARE_7));
        end
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          idx = IDX_W'($urandom_range(1, 15));
        end else if (pick < 95) begin
          idx = IDX_W'($urandom_range(0, POOL_ENTRIES - 1));
        end else if (pick < 97) begin
          idx = ROOT_ENTRY;
        end else begin
          idx = TOP_ENTRY;
        end
        send_request(op, idx);
      end
    end

    // drain and verdict
    settle();
    if (failures == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
